### hw/rtl/bship_pkg.sv
`default_nettype none

package bship_pkg;

  localparam int unsigned COORD_WIDTH = 11;
  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STEP_W      = 31;
  localparam int unsigned ITER_W      = 16;
  localparam int unsigned SHADE_W     = 8;
  localparam int unsigned NUM_W       = ITER_W + SHADE_W;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [SHADE_W-1:0] SHADE_INSIDE = SHADE_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH_RE,
    REG_TOP_IM,
    REG_PIXEL_STEP,
    REG_MAX_ITER
  } cfg_reg_e;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [ITER_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [SHADE_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/bship_div.sv
`default_nettype none

// Restoring divider for the shade: one quotient bit per cycle, MSB first.
// The quotient is known to fit in SHADE_W bits (count is below the limit).
module bship_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bship_pkg::div_req_t req_i,
  output bship_pkg::div_res_t      res_o
);
  import bship_pkg::*;

  localparam int unsigned STEP_CNT_W = $clog2(SHADE_W);

  logic                  active_q;
  logic [STEP_CNT_W-1:0] step_q;
  logic [NUM_W-1:0]      rem_q;
  logic [NUM_W-1:0]      dsh_q;
  logic [SHADE_W-1:0]    quot_q;
  logic                  done_q;

  logic                  fits;
  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        step_q   <= STEP_CNT_W'(SHADE_W - 1);
      end else if (active_q) begin
        if (step_q == '0) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end else begin
          step_q <= step_q - STEP_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      // align the divisor with the top quotient bit
      dsh_q  <= NUM_W'(req_i.den) << (SHADE_W - 1);
      quot_q <= '0;
    end else if (active_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[SHADE_W-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

`default_nettype wire

### hw/rtl/burning_ship_escape_time.sv
`default_nettype none

// Channel   Signals                               Handshake
// -------   -----------------------------------   ---------------------------
// pixel     start, busy, column_i, row_i          beat when start && !busy
// result    done_o, shade_o, escaped_o            beat when done_o (1 cycle)
// config    cfg_we_i, cfg_idx_i, cfg_data_i       write when cfg_we_i
//
// A pixel that never escapes runs N updates when N+1 is the limit; one that
// escapes after update N then runs the shade divider. All of it runs
// through one signed 32x32 multiplier, three products per update, plus a
// divider for the shade. busy stays high until the result beat.
// Reset loads the register defaults; results cannot be stalled.
module burning_ship_escape_time (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic [bship_pkg::COORD_WIDTH-1:0]  column_i,
  input  wire logic [bship_pkg::COORD_WIDTH-1:0]  row_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [bship_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bship_pkg::WORD_W-1:0]       cfg_data_i,
  output      logic                               done_o,
  output      logic [bship_pkg::SHADE_W-1:0]      shade_o,
  output      logic                               escaped_o
);
  import bship_pkg::*;

  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned EXT_W  = PROD_W + 2;
  localparam logic signed [EXT_W-1:0] WORD_MAX = EXT_W'(2147483647);
  localparam logic signed [EXT_W-1:0] WORD_MIN = -(EXT_W'(2147483647)) - EXT_W'(1);
  localparam logic [EXT_W-1:0] ESC_LIMIT = EXT_W'(4) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RE, S_IM, S_IMW, S_XX, S_YY, S_XY, S_UPD, S_DIV
  } state_e;

  function automatic logic signed [EXT_W-1:0] ext32(input logic signed [WORD_W-1:0] v);
    return {{(EXT_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

  function automatic logic signed [EXT_W-1:0] ext64(input logic signed [PROD_W-1:0] v);
    return {{(EXT_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_MAX[WORD_W-1:0];
    end else if (v < WORD_MIN) begin
      r = WORD_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [WORD_W-1:0] half_width_re_q;
  logic signed [WORD_W-1:0] top_im_q;
  logic [STEP_W-1:0]        pixel_step_q;
  logic [ITER_W-1:0]        max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_re_q <= WORD_W'(536870912);
      top_im_q        <= WORD_W'(268435456);
      pixel_step_q    <= STEP_W'(1048576);
      max_iter_q      <= ITER_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_WIDTH_RE: half_width_re_q <= cfg_data_i;
        REG_TOP_IM:        top_im_q        <= cfg_data_i;
        REG_PIXEL_STEP:    pixel_step_q    <= cfg_data_i[STEP_W-1:0];
        REG_MAX_ITER:      max_iter_q      <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                   state_q;
  logic [ITER_W-1:0]        cnt_q;
  logic                     done_q;
  logic [SHADE_W-1:0]       shade_q;
  logic                     escaped_q;

  logic [COORD_WIDTH-1:0]   col_q, row_q;
  logic signed [WORD_W-1:0] re_q, im_q, x_q, y_q;
  logic signed [PROD_W-1:0] prod_q, sqx_q, sqy_q;

  // shared multiplier
  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d;

  always_comb begin
    unique case (state_q)
      S_RE: begin
        mul_a = WORD_W'(col_q);
        mul_b = WORD_W'(pixel_step_q);
      end
      S_IM: begin
        mul_a = WORD_W'(row_q);
        mul_b = WORD_W'(pixel_step_q);
      end
      S_XX: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      S_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      S_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = y_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // setup sums
  logic signed [WORD_W-1:0] re_d, im_d;
  assign re_d = sat32(ext64(prod_q) - ext32(half_width_re_q));
  assign im_d = sat32(ext32(top_im_q) - ext64(prod_q));

  // map update: prod_q holds x*y, sqx_q and sqy_q the squares
  logic signed [PROD_W-1:0] t_sh, xx_sh, yy_sh;
  logic signed [WORD_W-1:0] t_w, xx_w, yy_w, d_w, nx_d, ny_d;
  logic signed [EXT_W-1:0]  twice_t, abs_t;

  always_comb begin
    t_sh    = prod_q >>> FRAC_BITS;
    xx_sh   = sqx_q >>> FRAC_BITS;
    yy_sh   = sqy_q >>> FRAC_BITS;
    t_w     = sat32(ext64(t_sh));
    xx_w    = sat32(ext64(xx_sh));
    yy_w    = sat32(ext64(yy_sh));
    twice_t = ext32(t_w) <<< 1;
    abs_t   = twice_t[EXT_W-1] ? -twice_t : twice_t;
    d_w     = sat32(abs_t);
    nx_d    = sat32(ext32(xx_w) - ext32(yy_w) + ext32(re_q));
    ny_d    = sat32(ext32(d_w) - ext32(im_q));
  end

  // escape test in S_XY: sqx_q = x*x, prod_q = y*y (both non-negative)
  logic [PROD_W-1:0] magx, magy;
  logic [EXT_W-1:0]  mag;
  logic              esc_hit;
  logic              more_iter;

  assign magx      = $unsigned(sqx_q) >> FRAC_BITS;
  assign magy      = $unsigned(prod_q) >> FRAC_BITS;
  assign mag       = EXT_W'(magx) + EXT_W'(magy);
  assign esc_hit   = (cnt_q != '0) && (mag > ESC_LIMIT);
  assign more_iter = ({1'b0, cnt_q} + (ITER_W+1)'(1)) < {1'b0, max_iter_q};

  div_req_t div_req;
  div_res_t div_res;

  assign div_req.start = (state_q == S_XY) && esc_hit;
  assign div_req.num   = {cnt_q, {SHADE_W{1'b0}}} - NUM_W'(cnt_q);
  assign div_req.den   = max_iter_q;

  bship_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      shade_q   <= '0;
      escaped_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) state_q <= S_RE;
        S_RE:   state_q <= S_IM;
        S_IM:   state_q <= S_IMW;
        S_IMW: begin
          cnt_q   <= '0;
          state_q <= S_XX;
        end
        S_XX:   state_q <= S_YY;
        S_YY:   state_q <= S_XY;
        S_XY: begin
          priority if (esc_hit) begin
            state_q <= S_DIV;
          end else if (more_iter) begin
            state_q <= S_UPD;
          end else begin
            done_q    <= 1'b1;
            shade_q   <= SHADE_INSIDE;
            escaped_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        S_UPD: begin
          cnt_q   <= cnt_q + ITER_W'(1);
          state_q <= S_XX;
        end
        S_DIV: begin
          if (div_res.done) begin
            done_q    <= 1'b1;
            shade_q   <= div_res.quot;
            escaped_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          col_q <= column_i;
          row_q <= row_i;
        end
      end
      S_IM:  re_q <= re_d;
      S_IMW: begin
        im_q <= im_d;
        x_q  <= '0;
        y_q  <= '0;
      end
      S_YY:  sqx_q <= prod_q;
      S_XY:  sqy_q <= prod_q;
      S_UPD: begin
        x_q <= nx_d;
        y_q <= ny_d;
      end
      default: ;
    endcase
  end

  assign busy      = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign shade_o   = shade_q;
  assign escaped_o = escaped_q;

endmodule

`default_nettype wire
